[hw/rtl/flq_pkg.sv]
// ----------------------------------------------------------------------------
// flq_pkg
// Types and codes shared by the fault log queue and its cells.
// ----------------------------------------------------------------------------
package flq_pkg;

  localparam logic       CMD_REPORT   = 1'b0;
  localparam logic       CMD_QUERY    = 1'b1;
  localparam logic       MODE_GET_CLR = 1'b0;

  localparam logic [1:0] KIND_NOTIFY  = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_PARTIAL   = 2'd1;
  localparam logic [1:0] ST_BAD_MODE  = 2'd2;

  localparam logic       REG_MAX_FAULTS = 1'b0;
  localparam logic       REG_NOTIFY_EN  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [1:0] fault_level;
    logic [2:0] fault_type;
    logic       query_mode;
    logic       count_only;
    logic [4:0] requested_count;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] out_level;
    logic [2:0] out_type;
    logic       lost_flag;
    logic [4:0] fault_count;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] level;
    logic [2:0] ftype;
  } fault_entry_t;

  typedef struct packed {
    logic         push;
    logic         pop;
    fault_entry_t entry;
  } cell_ctrl_t;

endpackage

[hw/rtl/flq_cell.sv]
// ----------------------------------------------------------------------------
// flq_cell
// One slot of the fault chain: loads a new fault or takes its neighbor's.
// ----------------------------------------------------------------------------
module flq_cell
  import flq_pkg::*;
(
  input  logic         clk,
  input  cell_ctrl_t   ctrl,
  input  logic         sel,
  input  fault_entry_t nbr,
  output fault_entry_t data
);

  always_ff @(posedge clk) begin
    if (ctrl.push && sel) begin
      data <= ctrl.entry;
    end else if (ctrl.pop) begin
      data <= nbr;
    end
  end

endmodule

[hw/rtl/fault_log_queue.sv]
// ----------------------------------------------------------------------------
// fault_log_queue
// Bounded fault log built as a shifting chain of cells with a sticky lost flag.
// ----------------------------------------------------------------------------
//   channel  | signals                              | role
//   item     | item_valid, item_ready, item         | report or query beat in
//   result   | result_valid, result_ready, result   | notify, entry, summary out
//   cfg      | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
// a report or a non-draining query is handled at accept; a query that drains n > 0
// entries steps through accept, one chain shift per entry, then the summary
// the oldest fault always sits in cell 0; a drain shifts the whole chain
// reset clears count, lost flag, notify enable; max_faults 16; cells not cleared
// a stalled result holds the item channel and the drain in place
// ----------------------------------------------------------------------------
module fault_log_queue
  import flq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_beat_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_beat_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {S_IDLE, S_DRAIN, S_SUM} state_t;

  state_t       state;
  logic [CW-1:0] count;
  logic [CW-1:0] remain;
  logic          lost;
  logic          lost_snap;
  logic [4:0]    take_snap;
  logic          partial_snap;
  logic [4:0]    max_faults;
  logic          notify_enable;

  fault_entry_t  cells [DEPTH];
  cell_ctrl_t    ctrl;

  logic          accept;
  logic          slot_free;
  logic [LW-1:0] limit;
  logic          has_room;
  logic          short_req;
  logic [LW-1:0] take_lw;
  logic          load_out;
  out_beat_t     out_next;

  assign cfg_ready  = 1'b1;
  assign slot_free  = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE) && slot_free;
  assign accept     = item_valid && item_ready;

  always_comb begin
    limit     = (LW'(max_faults) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_faults);
    has_room  = LW'(count) < limit;
    short_req = LW'(item.requested_count) < LW'(count);
    take_lw   = short_req ? LW'(item.requested_count) : LW'(count);

    ctrl.entry = '{level: item.fault_level, ftype: item.fault_type};
    ctrl.push  = accept && (item.cmd == CMD_REPORT) && (max_faults != 5'd0) && has_room;
    ctrl.pop   = (state == S_DRAIN) && slot_free;

    load_out = 1'b0;
    out_next = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.cmd == CMD_REPORT) begin
            load_out           = notify_enable;
            out_next.kind      = KIND_NOTIFY;
            out_next.out_level = item.fault_level;
            out_next.out_type  = item.fault_type;
            out_next.lost_flag = lost;
            out_next.last      = 1'b1;
          end else if (item.query_mode != MODE_GET_CLR) begin
            load_out        = 1'b1;
            out_next.kind   = KIND_SUMMARY;
            out_next.status = ST_BAD_MODE;
            out_next.last   = 1'b1;
          end else if (item.count_only) begin
            load_out             = 1'b1;
            out_next.kind        = KIND_SUMMARY;
            out_next.lost_flag   = lost;
            out_next.fault_count = 5'(count);
            out_next.status      = ST_SUCCESS;
            out_next.last        = 1'b1;
          end else if (take_lw == '0) begin
            load_out             = 1'b1;
            out_next.kind        = KIND_SUMMARY;
            out_next.lost_flag   = lost;
            out_next.fault_count = 5'd0;
            out_next.status      = short_req ? ST_PARTIAL : ST_SUCCESS;
            out_next.last        = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        load_out           = slot_free;
        out_next.kind      = KIND_ENTRY;
        out_next.out_level = cells[0].level;
        out_next.out_type  = cells[0].ftype;
      end
      S_SUM: begin
        load_out             = slot_free;
        out_next.kind        = KIND_SUMMARY;
        out_next.lost_flag   = lost_snap;
        out_next.fault_count = take_snap;
        out_next.status      = partial_snap ? ST_PARTIAL : ST_SUCCESS;
        out_next.last        = 1'b1;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fault_entry_t nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = cells[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    flq_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .sel  (count == CW'(i)),
      .nbr  (nbr),
      .data (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      count         <= '0;
      lost          <= 1'b0;
      max_faults    <= 5'd16;
      notify_enable <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_FAULTS: max_faults    <= cfg_data;
          REG_NOTIFY_EN:  notify_enable <= cfg_data[0];
          default:        max_faults    <= max_faults;
        endcase
      end

      if (load_out) begin
        result_valid <= 1'b1;
        result       <= out_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (ctrl.push) begin
        count <= count + CW'(1);
      end else if (ctrl.pop) begin
        count <= count - CW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.cmd == CMD_REPORT) begin
              if ((max_faults != 5'd0) && !has_room) begin
                lost <= 1'b1;
              end
            end else if (item.query_mode == MODE_GET_CLR) begin
              lost         <= 1'b0;
              lost_snap    <= lost;
              take_snap    <= 5'(take_lw);
              partial_snap <= short_req;
              remain       <= CW'(take_lw);
              if (!item.count_only && (take_lw != '0)) begin
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          if (ctrl.pop) begin
            remain <= remain - CW'(1);
            if (remain == CW'(1)) begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/flq_checker.sv]
// ----------------------------------------------------------------------------
// flq_checker
// Port-level checks on the result stream of the fault log queue.
// ----------------------------------------------------------------------------
module flq_checker
  import flq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input out_beat_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat right after reset");

  a_entry_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_ENTRY) |-> !result.last)
    else $error("drained entry marked last");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_SUMMARY) |-> result.last)
    else $error("summary not marked last");

  a_bad_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_BAD_MODE)
      |-> (result.fault_count == 5'd0) && !result.lost_flag)
    else $error("bad mode summary carries data");

endmodule

bind fault_log_queue flq_checker u_flq_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[verif/tb_fault_log_queue.sv]
// ----------------------------------------------------------------------------
// tb_fault_log_queue
// Self-checking bench for the fault log: a table of directed beats with a few
// hand-written answers, then random report and query traffic across several
// limit and notify settings, every result checked against a local model of
// the log with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_fault_log_queue;
  import flq_pkg::*;

  localparam int   DEPTH            = 16;
  localparam int   QUIET_LIMIT      = 2000;
  localparam int   SETTLE_CYCLES    = 4;
  localparam int   PHASES           = 8;
  localparam int   BEATS_PER_PHASE  = 25;
  localparam logic MODE_UNSUPPORTED = 1'b1;

  typedef struct {
    bit        is_cfg;
    logic      idx;
    logic [4:0] val;
    in_beat_t  beat;
    bit        fixed;
    out_beat_t want;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  in_beat_t   item;
  logic       result_valid;
  logic       result_ready;
  out_beat_t  result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [4:0] cfg_data;

  // model of the log
  fault_entry_t log_mem [DEPTH];
  int           log_head  = 0;
  int           log_count = 0;
  logic         log_lost  = 1'b0;
  logic [4:0]   limit_reg = 5'd16;
  logic         notify_reg = 1'b0;

  out_beat_t pending_results [$];
  int        errors   = 0;
  bit        idle_on  = 1'b0;
  bit        stall_on = 1'b0;

  fault_log_queue #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void apply_to_log(input in_beat_t b, ref out_beat_t res [$]);
    out_beat_t r;
    int        lim;
    int        take;
    logic      lost;
    res.delete();
    r = '0;
    if (b.cmd == CMD_REPORT) begin
      lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
      if (notify_reg) begin
        r.kind      = KIND_NOTIFY;
        r.out_level = b.fault_level;
        r.out_type  = b.fault_type;
        r.lost_flag = log_lost;
        r.last      = 1'b1;
        res.insert(res.size(), r);
      end
      if (limit_reg != 0) begin
        if (log_count < lim) begin
          log_mem[(log_head + log_count) % DEPTH] = '{b.fault_level, b.fault_type};
          log_count++;
        end else begin
          log_lost = 1'b1;
        end
      end
    end else if (b.query_mode != MODE_GET_CLR) begin
      r.kind   = KIND_SUMMARY;
      r.status = ST_BAD_MODE;
      r.last   = 1'b1;
      res.insert(res.size(), r);
    end else begin
      lost     = log_lost;
      log_lost = 1'b0;
      if (b.count_only) begin
        r.kind        = KIND_SUMMARY;
        r.lost_flag   = lost;
        r.fault_count = 5'(log_count);
        r.status      = ST_SUCCESS;
        r.last        = 1'b1;
        res.insert(res.size(), r);
      end else begin
        take = (b.requested_count < log_count) ? b.requested_count : log_count;
        for (int i = 0; i < take; i++) begin
          r           = '0;
          r.kind      = KIND_ENTRY;
          r.out_level = log_mem[log_head].level;
          r.out_type  = log_mem[log_head].ftype;
          res.insert(res.size(), r);
          log_head = (log_head + 1) % DEPTH;
        end
        log_count -= take;
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.lost_flag   = lost;
        r.fault_count = 5'(take);
        r.status      = (b.requested_count < take + log_count) ? ST_PARTIAL : ST_SUCCESS;
        r.last        = 1'b1;
        res.insert(res.size(), r);
      end
    end
  endfunction

  function automatic in_beat_t report_beat(logic [1:0] lvl, logic [2:0] typ);
    in_beat_t b;
    b             = '0;
    b.cmd         = CMD_REPORT;
    b.fault_level = lvl;
    b.fault_type  = typ;
    return b;
  endfunction

  function automatic in_beat_t query_beat(logic mode, logic conly, logic [4:0] req);
    in_beat_t b;
    b                 = '0;
    b.cmd             = CMD_QUERY;
    b.query_mode      = mode;
    b.count_only      = conly;
    b.requested_count = req;
    return b;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, logic [4:0] val);
    plan_row_t p;
    p        = '{default: '0};
    p.is_cfg = 1'b1;
    p.idx    = idx;
    p.val    = val;
    return p;
  endfunction

  function automatic plan_row_t beat_row(in_beat_t b, bit fixed = 1'b0,
                                         out_beat_t want = '0);
    plan_row_t p;
    p       = '{default: '0};
    p.beat  = b;
    p.fixed = fixed;
    p.want  = want;
    return p;
  endfunction

  function automatic in_beat_t random_beat(int report_pct);
    logic [31:0] rnd;
    in_beat_t    b;
    rnd = $urandom;
    b   = rnd[$bits(in_beat_t)-1:0];
    if ($urandom_range(1, 100) <= report_pct) begin
      b.cmd = CMD_REPORT;
    end else begin
      b.cmd        = CMD_QUERY;
      b.query_mode = ($urandom_range(1, 10) == 1) ? MODE_UNSUPPORTED : MODE_GET_CLR;
      b.count_only = ($urandom_range(1, 4) == 1);
      if ($urandom_range(0, 3) == 0)
        b.requested_count = 5'($urandom_range(0, 31));
      else
        b.requested_count = 5'($urandom_range(0, log_count + 1));
    end
    return b;
  endfunction

  // wait until the log has answered everything, then let it settle
  task automatic hold_until_drained(int settle);
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    hold_until_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_FAULTS: limit_reg  = val;
      REG_NOTIFY_EN:  notify_reg = val[0];
    endcase
  endtask

  task automatic send_beat(in_beat_t b, bit fixed, out_beat_t want);
    out_beat_t   res [$];
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    apply_to_log(b, res);
    if (fixed)
      pending_results.insert(pending_results.size(), want);
    else
      foreach (res[i]) pending_results.insert(pending_results.size(), res[i]);
    item_valid <= 1'b1;
    item       <= b;
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result side
  initial begin : result_sink
    int unsigned hold;
    out_beat_t   want;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = stall_on ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: kind %0d", result.kind);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind",        5'(want.kind),      5'(result.kind));
        check_field("out_level",   5'(want.out_level), 5'(result.out_level));
        check_field("out_type",    5'(want.out_type),  5'(result.out_type));
        check_field("lost_flag",   5'(want.lost_flag), 5'(result.lost_flag));
        check_field("fault_count", want.fault_count,   result.fault_count);
        check_field("status",      5'(want.status),    5'(result.status));
        check_field("last",        5'(want.last),      5'(result.last));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[fault_log_queue] ERROR");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [$];
    logic [4:0] cap;
    int         report_pct;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_MAX_FAULTS;
    cfg_data   <= '0;

    // directed table
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b1, 5'd0), 1'b1,
                   '{KIND_SUMMARY, 2'd0, 3'd0, 1'b0, 5'd0, ST_SUCCESS, 1'b1}));
    plan.insert(plan.size(), beat_row(query_beat(MODE_UNSUPPORTED, 1'b1, 5'd31), 1'b1,
                   '{KIND_SUMMARY, 2'd0, 3'd0, 1'b0, 5'd0, ST_BAD_MODE, 1'b1}));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b0, 5'd0), 1'b1,
                   '{KIND_SUMMARY, 2'd0, 3'd0, 1'b0, 5'd0, ST_SUCCESS, 1'b1}));
    plan.insert(plan.size(), cfg_row(REG_NOTIFY_EN, 5'd1));
    plan.insert(plan.size(), beat_row(report_beat(2'd3, 3'd7), 1'b1,
                   '{KIND_NOTIFY, 2'd3, 3'd7, 1'b0, 5'd0, ST_SUCCESS, 1'b1}));
    plan.insert(plan.size(), beat_row(report_beat(2'd0, 3'd0), 1'b1,
                   '{KIND_NOTIFY, 2'd0, 3'd0, 1'b0, 5'd0, ST_SUCCESS, 1'b1}));
    plan.insert(plan.size(), beat_row(report_beat(2'd1, 3'd5)));
    plan.insert(plan.size(), beat_row(report_beat(2'd2, 3'd2)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b1, 5'd0)));
    // limit dropped under the stored count
    plan.insert(plan.size(), cfg_row(REG_MAX_FAULTS, 5'd2));
    plan.insert(plan.size(), beat_row(report_beat(2'd2, 3'd6)));
    plan.insert(plan.size(), beat_row(report_beat(2'd1, 3'd1)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b1, 5'd0)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b0, 5'd2)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_UNSUPPORTED, 1'b0, 5'd16)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b0, 5'd31)));
    // recording off
    plan.insert(plan.size(), cfg_row(REG_MAX_FAULTS, 5'd0));
    plan.insert(plan.size(), beat_row(report_beat(2'd3, 3'd0)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b1, 5'd0)));
    // limit above depth, no notify
    plan.insert(plan.size(), cfg_row(REG_MAX_FAULTS, 5'd31));
    plan.insert(plan.size(), cfg_row(REG_NOTIFY_EN, 5'd0));
    plan.insert(plan.size(), beat_row(report_beat(2'd2, 3'd3)));
    plan.insert(plan.size(), beat_row(report_beat(2'd1, 3'd7)));
    plan.insert(plan.size(), beat_row(query_beat(MODE_GET_CLR, 1'b0, 5'd16)));
    plan.insert(plan.size(), cfg_row(REG_MAX_FAULTS, 5'd16));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_reg(plan[i].idx, plan[i].val);
      else
        send_beat(plan[i].beat, plan[i].fixed, plan[i].want);
    end

    // random traffic
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap = 5'd16;
        1:       cap = 5'd0;
        2:       cap = 5'd31;
        3:       cap = 5'd1;
        4:       cap = 5'($urandom_range(2, 15));
        5:       cap = 5'($urandom_range(17, 31));
        default: cap = 5'($urandom_range(0, 31));
      endcase
      write_reg(REG_MAX_FAULTS, cap);
      write_reg(REG_NOTIFY_EN,
                (ph == 0) ? 5'd1 : (ph == 1) ? 5'd0 : 5'($urandom_range(0, 1)));
      report_pct = (ph == 2) ? 90 : (ph == 3) ? 70 : 60;
      idle_on    = (ph % 3 != 1);
      stall_on   = (ph % 4 != 2);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        if (ph == 4 && k == BEATS_PER_PHASE / 2)
          hold_until_drained(0);
        send_beat(random_beat(report_pct), 1'b0, '0);
      end
    end

    hold_until_drained(8);
    if (errors == 0) begin
      $display("[fault_log_queue] OK");
    end else begin
      $display("[fault_log_queue] ERROR");
    end
    $finish;
  end

endmodule
